FILE: rtl/core/tbdm_pkg.sv
// Shared widths, register indexes and code values for the two-bit delta decoder.
package tbdm_pkg;

    localparam int BYTE_W   = 8;
    localparam int STEP_W   = 9;
    localparam int ACC_W    = 18;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CODES_PER_BYTE = 4;
    localparam int IDX_W    = $clog2(CODES_PER_BYTE);

    // leak = acc * 255 / 256, product held in ACC_W + LEAK_SHIFT bits
    localparam int LEAK_SHIFT = 8;
    localparam int PROD_W     = ACC_W + LEAK_SHIFT;

    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;
    typedef logic [STEP_W-1:0]         t_step;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [1:0]                t_code;

    localparam t_cfg_idx CFG_SMALL_STEP = 2'd0;
    localparam t_cfg_idx CFG_LARGE_STEP = 2'd1;

    localparam t_step SMALL_STEP_RST = 9'd160;
    localparam t_step LARGE_STEP_RST = 9'd494;

    localparam t_code CODE_UP_SMALL   = 2'd0;
    localparam t_code CODE_UP_LARGE   = 2'd1;
    localparam t_code CODE_DOWN_SMALL = 2'd2;
    localparam t_code CODE_DOWN_LARGE = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODES_PER_BYTE - 1);

    localparam t_sample SAMPLE_MAX = 16'sh7FFF;
    localparam t_sample SAMPLE_MIN = 16'sh8000;

endpackage

FILE: rtl/core/two_bit_delta_mod_decoder.sv
// Two-bit delta-modulation decoder with leaky integrator: top level.
//
//  channel | direction | handshake                 | beat payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_code_byte, i_restart, i_final_byte
//  out     | output    | o_out_valid / i_out_ready | o_sample, o_last_of_byte, o_packet_end
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One input beat yields four output beats, one per cycle while the output is
//  not stalled. The rate is set by the result port (one sample per beat) and
//  the accumulator loop, which does one leak-and-step per cycle.
//  The next byte is taken on the same edge that issues the fourth sample.
//  Reset (synchronous, active low) zeroes the accumulator, empties the byte
//  holder and output register, and reloads the step registers (160 / 494).
//  A stall on the output freezes the decode; nothing is dropped.
module two_bit_delta_mod_decoder
    import tbdm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_code_byte,
    input  logic                 i_restart,
    input  logic                 i_final_byte,
    // sample output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                 o_last_of_byte,
    output logic                 o_packet_end,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [STEP_W-1:0]    i_cfg_data
);

    // ---------------- configuration ----------------
    t_step r_small_step;
    t_step r_large_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_step <= SMALL_STEP_RST;
            r_large_step <= LARGE_STEP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SMALL_STEP: r_small_step <= i_cfg_data;
                CFG_LARGE_STEP: r_large_step <= i_cfg_data;
                default: ; // unmapped index, ignored
            endcase
        end
    end

    // ---------------- byte holder ----------------
    // r_codes shifts left by one code per sample, so the active code is
    // always in the top two bits.
    logic              r_busy;
    logic [BYTE_W-1:0] r_codes;
    logic              r_final;
    logic [IDX_W-1:0]  r_idx;
    t_acc              r_acc;

    // output register
    logic              r_out_valid;
    t_sample           r_sample;
    logic              r_last;
    logic              r_pend;

    logic advance;
    logic last_code;
    logic in_accept;

    // a sample can be produced when the output register is empty or drains
    assign advance   = r_busy && (!r_out_valid || i_out_ready);
    assign last_code = (r_idx == LAST_IDX);
    assign o_in_ready = !r_busy || (advance && last_code);
    assign in_accept  = i_in_valid && o_in_ready;

    // ---------------- leak and step ----------------
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_rnd;
    t_acc                     leaked;
    logic signed [ACC_W:0]    step_s;
    logic signed [ACC_W:0]    sum;
    t_acc                     n_acc;
    t_sample                  n_sample;

    always_comb begin
        // acc * 255 = acc * 256 - acc
        prod = {r_acc, {LEAK_SHIFT{1'b0}}} - PROD_W'(r_acc);
        // divide by 256 truncating toward zero: bias negatives before shift
        prod_rnd = prod[PROD_W-1] ? (prod + PROD_W'((1 << LEAK_SHIFT) - 1)) : prod;
        leaked   = prod_rnd[PROD_W-1:LEAK_SHIFT];

        case (r_codes[BYTE_W-1 -: 2])
            CODE_UP_SMALL:   step_s =  $signed({{(ACC_W+1-STEP_W){1'b0}}, r_small_step});
            CODE_UP_LARGE:   step_s =  $signed({{(ACC_W+1-STEP_W){1'b0}}, r_large_step});
            CODE_DOWN_SMALL: step_s = -$signed({{(ACC_W+1-STEP_W){1'b0}}, r_small_step});
            CODE_DOWN_LARGE: step_s = -$signed({{(ACC_W+1-STEP_W){1'b0}}, r_large_step});
            default:         step_s = '0;
        endcase

        sum   = {leaked[ACC_W-1], leaked} + step_s;
        // leak bounds |acc| to 18 bits, the top bit is redundant
        n_acc = sum[ACC_W-1:0];

        // saturate to 16 bits: overflow when the top bits disagree
        if (!n_acc[ACC_W-1] && (n_acc[ACC_W-2:SAMPLE_W-1] != '0)) begin
            n_sample = SAMPLE_MAX;
        end else if (n_acc[ACC_W-1] && (n_acc[ACC_W-2:SAMPLE_W-1] != '1)) begin
            n_sample = SAMPLE_MIN;
        end else begin
            n_sample = n_acc[SAMPLE_W-1:0];
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // restart clears after any final step of the previous byte
            if (in_accept && i_restart) begin
                r_acc <= '0;
            end else if (advance) begin
                r_acc <= n_acc;
            end

            if (in_accept) begin
                r_idx <= '0;
            end else if (advance) begin
                r_idx <= r_idx + 1'b1;
            end

            if (in_accept) begin
                r_busy <= 1'b1;
            end else if (advance && last_code) begin
                r_busy <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_codes <= i_code_byte;
            r_final <= i_final_byte;
        end else if (advance) begin
            r_codes <= {r_codes[BYTE_W-3:0], 2'b00};
        end
        if (advance) begin
            r_sample <= n_sample;
            r_last   <= last_code;
            r_pend   <= last_code && r_final;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_sample;
    assign o_last_of_byte = r_last;
    assign o_packet_end   = r_pend;

    // ---------------- assertions ----------------
    a_pend_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_packet_end || o_last_of_byte))
        else $error("packet_end without last_of_byte");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_busy && (r_idx == '0)))
        else $error("accepted byte did not start at first code");

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == '0))
        else $error("code index moved while idle");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && last_code && !i_in_valid) |=> !r_busy)
        else $error("holder not freed after fourth sample");

endmodule

FILE: tb/two_bit_delta_mod_decoder_tb.sv
// Self-checking testbench for the two-bit delta-modulation decoder with leaky integrator.
module two_bit_delta_mod_decoder_tb;
    import tbdm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Leak factor: acc * 255 / 256, quotient truncated toward zero.
    localparam int LEAK_NUM = 255;
    localparam int LEAK_DEN = 256;

    // Cycles without any beat on any channel before the run is declared hung.
    // The worst honest gap is a receiver stall, a sender gap between bursts,
    // or the short settle pause between phases.
    localparam int HANG_LIMIT = 2000;

    // Register indexes that the block does not implement; writes must be dropped.
    localparam t_cfg_idx CFG_UNUSED_2 = 2'd2;
    localparam t_cfg_idx CFG_UNUSED_3 = 2'd3;

    // Bytes that repeat one code four times, used for long monotonic runs.
    localparam logic [BYTE_W-1:0] RUN_BYTES [4] = '{8'h00, 8'h55, 8'hAA, 8'hFF};

    typedef struct packed {
        logic [BYTE_W-1:0] codes;
        logic              restart;
        logic              fin;
    } t_code_beat;

    typedef struct packed {
        t_sample sample;
        logic    last_of_byte;
        logic    packet_end;
    } t_sample_beat;

    // ---------------------------------------------------------------------
    // Clock, reset and block inputs (all start at known values)
    // ---------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              i_in_valid = 1'b0;
    logic [BYTE_W-1:0] i_code_byte = '0;
    logic              i_restart = 1'b0;
    logic              i_final_byte = 1'b0;
    logic              i_out_ready = 1'b0;
    logic              i_cfg_valid = 1'b0;
    t_cfg_idx          i_cfg_index = CFG_SMALL_STEP;
    t_step             i_cfg_data = '0;

    logic              o_in_ready;
    logic              o_out_valid;
    t_sample           o_sample;
    logic              o_last_of_byte;
    logic              o_packet_end;
    logic              o_cfg_ready;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    two_bit_delta_mod_decoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_code_byte    (i_code_byte),
        .i_restart      (i_restart),
        .i_final_byte   (i_final_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample       (o_sample),
        .o_last_of_byte (o_last_of_byte),
        .o_packet_end   (o_packet_end),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // ---------------------------------------------------------------------
    // Decoder model: its own copy of the step registers and the accumulator
    // ---------------------------------------------------------------------
    t_step small_step_m = SMALL_STEP_RST;
    t_step large_step_m = LARGE_STEP_RST;
    t_acc  acc_m = '0;

    t_code_beat   byte_queue[$];    // bytes waiting to be driven
    t_sample_beat want_samples[$];  // samples the block still owes us
    int           n_fail = 0;

    // Decode one accepted byte: four leak-and-step updates, MSB pair first.
    function automatic void decode_byte_model(input t_code_beat b);
        t_code        code;
        int           leaked;
        int           acc_next;
        t_sample_beat s;
        if (b.restart) acc_m = '0;
        for (int k = 0; k < CODES_PER_BYTE; k++) begin
            code = b.codes[BYTE_W - 1 - 2 * k -: 2];
            // signed int division truncates toward zero, as the leak requires
            leaked = (int'(acc_m) * LEAK_NUM) / LEAK_DEN;
            case (code)
                CODE_UP_SMALL:   acc_next = leaked + int'(small_step_m);
                CODE_UP_LARGE:   acc_next = leaked + int'(large_step_m);
                CODE_DOWN_SMALL: acc_next = leaked - int'(small_step_m);
                default:         acc_next = leaked - int'(large_step_m);
            endcase
            acc_m = t_acc'(acc_next);
            // only the reported sample saturates; the accumulator runs free
            if (acc_next > int'(SAMPLE_MAX)) s.sample = SAMPLE_MAX;
            else if (acc_next < int'(SAMPLE_MIN)) s.sample = SAMPLE_MIN;
            else s.sample = t_sample'(acc_next);
            s.last_of_byte = (k == CODES_PER_BYTE - 1);
            s.packet_end = s.last_of_byte & b.fin;
            want_samples.push_back(s);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Byte driver: bursts of random length separated by random gaps.
    // About a third of the bursts have no gap after them, giving
    // back-to-back stretches at full rate.
    // ---------------------------------------------------------------------
    int         burst_left = 0;
    int         gap_left = 0;
    t_code_beat drv_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            // beat taken at this edge: predict from the payload on the wires
            if (i_in_valid && o_in_ready)
                decode_byte_model('{i_code_byte, i_restart, i_final_byte});
            // payload may only change once the current beat is gone
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    drv_beat = byte_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_code_byte <= drv_beat.codes;
                    i_restart <= drv_beat.restart;
                    i_final_byte <= drv_beat.fin;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sample receiver: ready follows a rotating 16-bit pattern, reloaded
    // whenever the 6-bit age counter wraps. Bit 0 is forced high on reload so
    // no stall goes on forever; an all-ones pattern gives stall-free stretches.
    // ---------------------------------------------------------------------
    logic [15:0] stall_pat = 16'hFFFF;
    logic [5:0]  pat_age = '0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= stall_pat[0];
            pat_age <= pat_age + 1'b1;
            if (pat_age == '1) begin
                case ($urandom_range(0, 3))
                    0: stall_pat <= 16'hFFFF;
                    1: stall_pat <= 16'($urandom) | 16'h0001;
                    2: stall_pat <= (16'($urandom) & 16'($urandom)) | 16'h0001;
                    default: stall_pat <= 16'($urandom) | 16'($urandom) | 16'h0001;
                endcase
            end else begin
                stall_pat <= {stall_pat[0], stall_pat[15:1]};
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sample checker: every beat against the oldest prediction
    // ---------------------------------------------------------------------
    t_sample_beat want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (want_samples.size() == 0) begin
                $error("sample beat %0d with nothing predicted", o_sample);
                n_fail++;
            end else begin
                want = want_samples.pop_front();
                if (o_sample !== want.sample) begin
                    $error("sample: expected %0d, got %0d", want.sample, o_sample);
                    n_fail++;
                end
                if (o_last_of_byte !== want.last_of_byte) begin
                    $error("last_of_byte: expected %0b, got %0b",
                           want.last_of_byte, o_last_of_byte);
                    n_fail++;
                end
                if (o_packet_end !== want.packet_end) begin
                    $error("packet_end: expected %0b, got %0b",
                           want.packet_end, o_packet_end);
                    n_fail++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Hang detector: counts cycles with no beat on any channel
    // ---------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // One register write; the model takes it on the edge the beat is accepted.
    task automatic write_reg(input t_cfg_idx idx, input t_step val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SMALL_STEP: small_step_m = val;
            CFG_LARGE_STEP: large_step_m = val;
            default: ;  // unimplemented index, nothing changes
        endcase
    endtask

    // Packet of identical bytes: restart on the first, final on the last.
    task automatic push_run(input logic [BYTE_W-1:0] codes, input int len);
        for (int i = 0; i < len; i++)
            byte_queue.push_back('{codes, i == 0, i == len - 1});
    endtask

    // Mostly well-formed packets with random content; a few miss their
    // restart or final flag, or carry one in the middle. Now and then a long
    // monotonic run drives the accumulator past the sample range.
    task automatic fill_random(input int n);
        int         count;
        int         len;
        t_code_beat b;
        count = 0;
        while (count < n) begin
            if ($urandom_range(0, 7) == 0) begin
                len = $urandom_range(16, 28);
                push_run(RUN_BYTES[$urandom_range(0, 3)], len);
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    b.codes = BYTE_W'($urandom_range(0, 255));
                    b.restart = (i == 0) ? ($urandom_range(0, 7) != 0)
                                         : ($urandom_range(0, 15) == 0);
                    b.fin = (i == len - 1) ? ($urandom_range(0, 7) != 0)
                                           : ($urandom_range(0, 15) == 0);
                    byte_queue.push_back(b);
                end
            end
            count += len;
        end
    endtask

    // Block is idle once every byte is taken and every sample has come back.
    // A few extra cycles let the last output beat settle before a reg write.
    task automatic wait_drained();
        while (byte_queue.size() != 0 || i_in_valid || want_samples.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, at reset step values: each code alone, mixed orders,
        // restart with and without final, final alone, leak of both signs.
        byte_queue.push_back('{8'h00, 1'b1, 1'b0});
        byte_queue.push_back('{8'h55, 1'b0, 1'b0});
        byte_queue.push_back('{8'hAA, 1'b0, 1'b0});
        byte_queue.push_back('{8'hFF, 1'b0, 1'b0});
        byte_queue.push_back('{8'h1B, 1'b0, 1'b1});
        byte_queue.push_back('{8'hE4, 1'b1, 1'b1});
        byte_queue.push_back('{8'h00, 1'b1, 1'b0});
        byte_queue.push_back('{8'hFF, 1'b0, 1'b0});
        push_run(8'h55, 8);
        push_run(8'hFF, 4);
        wait_drained();

        // Writes to unimplemented indexes must leave the reset steps alone.
        write_reg(CFG_UNUSED_2, 9'h1FF);
        write_reg(CFG_UNUSED_3, 9'h000);
        fill_random(10);
        wait_drained();

        // Both steps zero: every code only leaks.
        write_reg(CFG_SMALL_STEP, 9'd0);
        write_reg(CFG_LARGE_STEP, 9'd0);
        byte_queue.push_back('{8'h1B, 1'b1, 1'b1});
        fill_random(10);
        wait_drained();

        // Maximum steps, with forced runs into both saturation limits.
        write_reg(CFG_SMALL_STEP, 9'd511);
        write_reg(CFG_LARGE_STEP, 9'd511);
        push_run(8'hFF, 24);
        push_run(8'h00, 24);
        fill_random(10);
        wait_drained();

        // One step zero, the other at its maximum, both ways round.
        write_reg(CFG_SMALL_STEP, 9'd0);
        write_reg(CFG_LARGE_STEP, 9'd511);
        fill_random(10);
        wait_drained();

        write_reg(CFG_SMALL_STEP, 9'd511);
        write_reg(CFG_LARGE_STEP, 9'd0);
        fill_random(10);
        wait_drained();

        // Tiny steps: the leak truncation dominates.
        write_reg(CFG_SMALL_STEP, 9'd1);
        write_reg(CFG_LARGE_STEP, 9'd2);
        fill_random(10);
        wait_drained();

        // Random step pairs.
        repeat (2) begin
            write_reg(CFG_SMALL_STEP, STEP_W'($urandom_range(0, 511)));
            write_reg(CFG_LARGE_STEP, STEP_W'($urandom_range(0, 511)));
            fill_random(10);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (want_samples.size() != 0) begin
            $error("%0d predicted samples never arrived", want_samples.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: two_bit_delta_mod_decoder.f
rtl/core/tbdm_pkg.sv
rtl/core/two_bit_delta_mod_decoder.sv
tb/two_bit_delta_mod_decoder_tb.sv
